// ----- hdl/md5_pkg.sv -----
// md5 package: constants, state encoding and round helper functions
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int BLOCK_WORDS = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_EMIT
	} md5_state_t;

	// control from sequencer to round core
	typedef struct packed {
		logic       start;
		logic [5:0] round;
		logic       step;
		logic       finish;
		logic       init;
	} md5_ctl_t;

	typedef logic [31:0] word_t;

	function automatic word_t round_const(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word index used by a round
	function automatic logic [3:0] word_sel(input logic [5:0] i);
		logic [3:0] k;
		case (i[5:4])
			2'd0: k = i[3:0];
			2'd1: k = 4'(5 * i[3:0] + 1);
			2'd2: k = 4'(3 * i[3:0] + 5);
			default: k = 4'(7 * i[3:0]);
		endcase
		return k;
	endfunction

endpackage

// ----- hdl/md5_stream_if.sv -----
// valid/ready stream interface with generic payload
interface md5_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/md5_round_core.sv -----
// round core: one md5 round per cycle on a block read from the word memory
module md5_round_core import md5_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  md5_ctl_t ctl,
	input  word_t    mem_word,
	output word_t    chain [4]
);
	word_t a_q, b_q, c_q, d_q;
	word_t h_q [4];
	word_t f, t, r;
	logic [4:0] s;

	// round function of the current group
	always_comb begin
		case (ctl.round[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		s = rot_amount(ctl.round);
		t = a_q + f + mem_word + round_const(ctl.round);
		r = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	// working and chaining registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
		end else if (ctl.init) begin
			h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
		end else if (ctl.finish) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
		end else if (ctl.step) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + r;
		end
	end

	assign chain = h_q;
endmodule

// ----- hdl/md5_message_digest_unit.sv -----
// md5 top level: byte packing, word memory, padding sequencer, digest output
// flow: after the closing word the sequencer pads, writes the length and runs the rounds,
// a second time when the padding spills into a second block; four digest words then go
// one per cycle while the sink is ready; input takes one byte word per cycle while loading,
// and stalls after every full block while the round loop reads the word memory
// reset: asynchronous active low, chaining words to the md5 initial value, count cleared
module md5_message_digest_unit import md5_pkg::*; (
	input logic clk,
	input logic arst_n,
	md5_stream_if.sink   in_ch,
	md5_stream_if.source out_ch
);
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_t;

	word_t      mem [BLOCK_WORDS];
	word_t      rd_q;
	logic [3:0] rd_addr;
	logic       we;
	logic [3:0] wr_addr;
	word_t      wr_data;

	md5_state_t st_q, st_d;
	logic [63:0] cnt_q;
	word_t       acc_q;
	logic [6:0]  rnd_q;
	logic [3:0]  pw_q;
	logic        fin_q;
	logic        pad_done_q;
	logic        len_done_q;
	logic [1:0]  oi_q;
	md5_ctl_t    ctl;
	word_t       chain [4];
	in_t         iw;
	logic        acc;
	logic [5:0]  pos, npos;
	word_t       merged, padw;
	logic        full;
	logic        long_pad;

	assign iw  = in_ch.data;
	assign acc = in_ch.valid && in_ch.ready;
	assign pos = cnt_q[8:3];
	assign npos = iw.byte_valid ? 6'(pos + 6'd1) : pos;
	assign in_ch.ready = (st_q == ST_LOAD);
	// pad byte still to place and no room left for the length in this block
	assign long_pad = !pad_done_q && (pos >= 6'd56);

	// merge incoming byte into the partial word
	always_comb begin
		merged = acc_q;
		case (pos[1:0])
			2'd0: merged = {24'd0, iw.data_byte};
			2'd1: merged[15:8] = iw.data_byte;
			2'd2: merged[23:16] = iw.data_byte;
			default: merged[31:24] = iw.data_byte;
		endcase
		full = iw.byte_valid && (pos == 6'd63);
	end

	// padding word, with 0x80 at the end position until the pad byte is placed
	always_comb begin
		padw = 32'd0;
		if (!pad_done_q && pw_q == pos[5:2]) begin
			padw = (pos[1:0] == 2'd0) ? 32'd0 : acc_q;
			case (pos[1:0])
				2'd0: padw[7:0] = PAD_BYTE;
				2'd1: padw[15:8] = PAD_BYTE;
				2'd2: padw[23:16] = PAD_BYTE;
				default: padw[31:24] = PAD_BYTE;
			endcase
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD: if (acc) begin
				if (full) st_d = ST_ROUND;
				else if (iw.end_of_message) st_d = ST_PAD;
			end
			ST_PAD: begin
				if (long_pad) begin
					if (pw_q == 4'd15) st_d = ST_ROUND;
				end else if (pw_q == 4'd13) begin
					st_d = ST_LEN;
				end
			end
			ST_LEN: if (pw_q == 4'd15) st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 7'd65) begin
				if (!fin_q) st_d = ST_LOAD;
				else if (len_done_q) st_d = ST_EMIT;
				else st_d = ST_PAD;
			end
			ST_EMIT: if (out_ch.ready && oi_q == 2'd3) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	// memory write and core control
	always_comb begin
		we = 1'b0; wr_addr = pw_q; wr_data = padw;
		ctl = '0;
		rd_addr = word_sel(rnd_q[5:0]);
		case (st_q)
			ST_LOAD: begin
				we = acc && iw.byte_valid && (pos[1:0] == 2'd3);
				wr_addr = pos[5:2];
				wr_data = merged;
			end
			ST_PAD: we = 1'b1;
			ST_LEN: begin
				we = 1'b1;
				wr_data = (pw_q == 4'd14) ? cnt_q[31:0] : cnt_q[63:32];
			end
			ST_ROUND: begin
				ctl.start = (rnd_q == 7'd0);
				ctl.step = (rnd_q != 7'd0) && (rnd_q != 7'd65);
				ctl.round = 6'(rnd_q - 7'd1);
				ctl.finish = (rnd_q == 7'd65);
			end
			ST_EMIT: ctl.init = out_ch.ready && oi_q == 2'd3;
			default: ;
		endcase
	end

	// block word memory
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD; cnt_q <= '0; rnd_q <= '0; pw_q <= '0;
			fin_q <= 1'b0; pad_done_q <= 1'b0; len_done_q <= 1'b0; oi_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_LOAD: if (acc) begin
					if (iw.byte_valid) cnt_q <= cnt_q + 64'd8;
					fin_q <= iw.end_of_message;
					pw_q <= npos[5:2];
				end
				ST_PAD: begin
					pw_q <= pw_q + 4'd1;
					if (st_d != ST_PAD) pad_done_q <= 1'b1;
				end
				ST_LEN: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) len_done_q <= 1'b1;
				end
				ST_ROUND: begin
					if (rnd_q == 7'd65) begin
						rnd_q <= '0;
						pw_q <= '0;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_EMIT: if (out_ch.ready) begin
					oi_q <= oi_q + 2'd1;
					if (oi_q == 2'd3) begin
						cnt_q <= '0;
						fin_q <= 1'b0;
						pad_done_q <= 1'b0;
						len_done_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// partial word register
	always_ff @(posedge clk) begin
		if (acc && iw.byte_valid) acc_q <= merged;
	end

	md5_round_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.mem_word (rd_q),
		.chain    (chain)
	);

	// digest output
	assign out_ch.valid = (st_q == ST_EMIT);
	assign out_ch.data  = {chain[oi_q], oi_q, (oi_q == 2'd3)};
endmodule

// ----- tb/md5_message_digest_unit_tb.sv -----
// testbench for the md5 digest unit: byte stream in, checked digest words out
`timescale 1ns / 1ps

module md5_message_digest_unit_tb;
	import md5_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} byte_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} digest_out_t;

	typedef struct {
		byte_word_t pl;
		bit         hold;
		bit         quiet;
	} stim_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int ITEM_TARGET = 420;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic clk;
	logic arst_n;

	md5_stream_if #(.payload_t(byte_word_t)) in_ch ();
	md5_stream_if #(.payload_t(digest_out_t)) out_ch ();

	md5_message_digest_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	stim_t       pending_words[$];
	digest_out_t expected_digests[$];
	int          error_count = 0;
	int          messages_sent = 0;
	int          bytes_sent = 0;
	int          digests_checked = 0;
	int          cycle_count = 0;

	// predictor state
	logic [31:0] chain_st[4];
	logic [7:0]  block_st[64];
	logic [63:0] bit_total;

	function automatic void init_chain();
		chain_st[0] = 32'h67452301;
		chain_st[1] = 32'hefcdab89;
		chain_st[2] = 32'h98badcfe;
		chain_st[3] = 32'h10325476;
		bit_total = '0;
	endfunction

	function automatic void compress_block_st();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, f, t;
		int grp, k, s;
		for (int i = 0; i < 16; i++)
			w[i] = {block_st[4*i+3], block_st[4*i+2], block_st[4*i+1], block_st[4*i]};
		a = chain_st[0]; b = chain_st[1]; c = chain_st[2]; d = chain_st[3];
		for (int i = 0; i < 64; i++) begin
			grp = i / 16;
			case (grp)
				0: begin f = (b & c) | (~b & d); k = i % 16; end
				1: begin f = (b & d) | (c & ~d); k = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; k = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); k = (7 * i) % 16; end
			endcase
			s = SHIFTS[grp * 4 + i % 4];
			t = a + f + w[k] + SINE_K[i];
			t = b + ((t << s) | (t >> (32 - s)));
			a = d; d = c; c = b; b = t;
		end
		chain_st[0] += a; chain_st[1] += b; chain_st[2] += c; chain_st[3] += d;
	endfunction

	// absorb one accepted word, queue the digest at the end of a message
	function automatic void absorb_word(byte_word_t wd);
		int pos;
		digest_out_t r;
		if (wd.byte_valid) begin
			pos = int'(bit_total[8:3]);
			block_st[pos] = wd.data_byte;
			bit_total += 64'd8;
			if (pos == 63)
				compress_block_st();
		end
		if (wd.end_of_message) begin
			pos = int'(bit_total[8:3]);
			block_st[pos] = 8'h80;
			for (int i = pos + 1; i < 64; i++)
				block_st[i] = 8'h00;
			if (pos >= 56) begin
				compress_block_st();
				for (int i = 0; i < 64; i++)
					block_st[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				block_st[56 + i] = bit_total[8*i +: 8];
			compress_block_st();
			for (int i = 0; i < 4; i++) begin
				r.digest_word = chain_st[i];
				r.word_index = 2'(i);
				r.last_word = (i == 3);
				expected_digests.push_back(r);
			end
			init_chain();
		end
	endfunction

	function automatic void add_word(logic [7:0] db, logic bv, logic eom, bit hold);
		stim_t s;
		s.pl.data_byte = db;
		s.pl.byte_valid = bv;
		s.pl.end_of_message = eom;
		s.hold = hold;
		s.quiet = 0;
		pending_words.push_back(s);
	endfunction

	// one message of n bytes with optional idle noise words
	function automatic int add_message(int n, bit noisy, bit hold);
		bit tail_eom;
		int cnt;
		cnt = 0;
		tail_eom = (n > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				add_word(8'($urandom), 1'b0, 1'b0, hold && i == 0);
				cnt++;
			end
			add_word(8'($urandom), 1'b1, tail_eom && i == n - 1, hold && i == 0);
			cnt++;
		end
		if (!tail_eom) begin
			add_word(8'($urandom), 1'b0, 1'b1, hold && n == 0);
			cnt++;
		end
		return cnt;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver
	stim_t cur_word;
	int    src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				absorb_word(in_ch.data);
				if (in_ch.data.byte_valid)
					bytes_sent++;
				if (in_ch.data.end_of_message)
					messages_sent++;
			end
			if (in_ch.valid && !in_ch.ready) begin
				in_ch.valid <= 1'b1;
			end else if (src_gap > 0) begin
				src_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() == 0 ||
					(pending_words[0].hold && expected_digests.size() != 0)) begin
				in_ch.valid <= 1'b0;
			end else begin
				cur_word = pending_words.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data <= cur_word.pl;
				if (!cur_word.quiet && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 6);
			end
		end
	end

	// monitor and ready pattern
	int  sink_gap = 0;
	bit  sink_quiet = 0;
	digest_out_t exp_d;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_digests.size() == 0) begin
					$error("digest word with nothing expected: %h", out_ch.data);
					error_count++;
				end else begin
					exp_d = expected_digests.pop_front();
					digests_checked++;
					if (out_ch.data.digest_word !== exp_d.digest_word) begin
						$error("digest_word expected %h actual %h",
							exp_d.digest_word, out_ch.data.digest_word);
						error_count++;
					end
					if (out_ch.data.word_index !== exp_d.word_index) begin
						$error("word_index expected %0d actual %0d",
							exp_d.word_index, out_ch.data.word_index);
						error_count++;
					end
					if (out_ch.data.last_word !== exp_d.last_word) begin
						$error("last_word expected %0d actual %0d",
							exp_d.last_word, out_ch.data.last_word);
						error_count++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 5);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("md5_message_digest_unit_tb NOT OK");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int n_items;
		int msg_no;
		int len_pick;
		int lens[9];
		lens = '{0, 55, 56, 57, 63, 64, 65, 119, 120};
		arst_n = 1'b0;
		init_chain();
		for (int i = 0; i < 64; i++)
			block_st[i] = 8'h00;

		// directed: empty message, extreme bytes, ignored bytes, byte with end mark
		n_items = 0;
		add_word(8'hff, 1'b0, 1'b0, 1'b0);
		add_word(8'h5a, 1'b0, 1'b1, 1'b0);
		add_word(8'hff, 1'b1, 1'b1, 1'b0);
		add_word(8'h00, 1'b1, 1'b0, 1'b0);
		add_word(8'h00, 1'b0, 1'b0, 1'b0);
		add_word(8'haa, 1'b0, 1'b1, 1'b0);
		add_word(8'h00, 1'b1, 1'b1, 1'b0);
		add_word(8'h00, 1'b0, 1'b1, 1'b0);
		n_items = 8;

		// random messages, lengths near the padding boundaries favored
		msg_no = 0;
		while (n_items < ITEM_TARGET) begin
			if ($urandom_range(0, 9) < 3)
				len_pick = lens[$urandom_range(0, 8)];
			else if ($urandom_range(0, 9) == 0)
				len_pick = $urandom_range(0, 140);
			else
				len_pick = $urandom_range(0, 40);
			n_items += add_message(len_pick, 1'b1, msg_no == 3);
			msg_no++;
		end
		for (int i = 0; i < 60 && i < pending_words.size(); i++)
			pending_words[pending_words.size() - 1 - i].quiet = 1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_ch.valid || expected_digests.size() != 0) begin
			if (pending_words.size() < 60)
				sink_quiet = 1;
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d messages with %0d bytes in total", messages_sent, bytes_sent);
		$display("checked %0d digest words against the predicted digests", digests_checked);
		if (error_count == 0 && expected_digests.size() == 0)
			$display("md5_message_digest_unit_tb OK");
		else
			$display("md5_message_digest_unit_tb NOT OK");
		$finish;
	end

endmodule
